[rtl/qssd_pkg.sv]
// Shared types, byte constants and the hex digit helper for the query string
// splitter and decoder.
// No dependencies; imported by qssd_decode and query_string_splitter_decoder.
package qssd_pkg;

   // Delimiter and escape bytes
   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_PCT   = 8'h25;
   localparam logic [7:0] CH_AMP   = 8'h26;
   localparam logic [7:0] CH_EQ    = 8'h3D;
   localparam logic [7:0] CH_SPACE = 8'h20;

   // Escape progress codes
   localparam logic [1:0] ESC_NONE  = 2'd0;
   localparam logic [1:0] ESC_PCT   = 2'd1;
   localparam logic [1:0] ESC_DIGIT = 2'd2;

   // Parser state carried from one byte to the next
   typedef struct packed {
      logic       value_phase;
      logic [1:0] escape_phase;
      logic [3:0] first_nibble;
      logic       first_was_hex;
      logic       pair_open;
   } parse_state_type;

   // One result beat
   typedef struct packed {
      logic       has_char;
      logic [7:0] out_byte;
      logic       in_value;
      logic       pair_end;
   } result_type;

   typedef struct packed {
      logic       ok;
      logic [3:0] val;
   } hex_digit_type;

   // Hex digit test and value; value is 0 for a non-hex byte
   function automatic hex_digit_type hex_digit(input logic [7:0] b);
      hex_digit_type d;
      d.ok  = 1'b1;
      d.val = 4'd0;
      if (b >= 8'h30 && b <= 8'h39) begin
         d.val = 4'(b - 8'h30);
      end else if (b >= 8'h41 && b <= 8'h46) begin
         d.val = 4'(b - 8'h41 + 8'd10);
      end else if (b >= 8'h61 && b <= 8'h66) begin
         d.val = 4'(b - 8'h61 + 8'd10);
      end else begin
         d.ok = 1'b0;
      end
      return d;
   endfunction

   // Value of an escape cut off after its first digit
   function automatic logic [7:0] cut_value(input parse_state_type s);
      return s.first_was_hex ? {4'd0, s.first_nibble} : 8'd0;
   endfunction

endpackage

[rtl/qssd_decode.sv]
// Next-state and result logic for one query string byte.
// Depends on qssd_pkg.
module qssd_decode (
   input  logic [7:0]               data_byte,
   input  logic                     last_byte,
   input  qssd_pkg::parse_state_type state_cur,
   output qssd_pkg::parse_state_type state_nxt,
   output logic                     emit,
   output qssd_pkg::result_type     result
);
   import qssd_pkg::*;

   logic          is_amp;
   logic          is_eq;
   logic          has;
   logic [7:0]    ch;
   logic          pend;
   hex_digit_type dig;
   parse_state_type s;

   assign is_amp = (data_byte == CH_AMP);
   assign is_eq  = (data_byte == CH_EQ) && !state_cur.value_phase;
   assign dig    = hex_digit(data_byte);

   always_comb begin
      s    = state_cur;
      has  = 1'b0;
      ch   = 8'd0;
      pend = 1'b0;

      if (is_amp || is_eq) begin
         // delimiter ends the piece; flush an escape cut after one digit
         if (state_cur.escape_phase == ESC_DIGIT) begin
            has = 1'b1;
            ch  = cut_value(state_cur);
         end
         s.escape_phase = ESC_NONE;
         if (is_amp) begin
            pend          = 1'b1;
            s.value_phase = 1'b0;
            s.pair_open   = 1'b0;
         end else begin
            s.value_phase = 1'b1;
            s.pair_open   = 1'b1;
            pend          = last_byte;
         end
      end else begin
         s.pair_open = 1'b1;
         case (state_cur.escape_phase)
            ESC_PCT: begin
               s.first_was_hex = dig.ok;
               s.first_nibble  = dig.val;
               s.escape_phase  = ESC_DIGIT;
            end
            ESC_DIGIT: begin
               has = 1'b1;
               if (!state_cur.first_was_hex) begin
                  ch = 8'd0;
               end else if (dig.ok) begin
                  ch = {state_cur.first_nibble, dig.val};
               end else begin
                  ch = {4'd0, state_cur.first_nibble};
               end
               s.escape_phase = ESC_NONE;
            end
            default: begin
               if (data_byte == CH_PCT) begin
                  s.escape_phase = ESC_PCT;
               end else if (data_byte == CH_PLUS) begin
                  has = 1'b1;
                  ch  = CH_SPACE;
               end else begin
                  has = 1'b1;
                  ch  = data_byte;
               end
            end
         endcase
         // end of string closes the pair and any half escape
         if (last_byte) begin
            if (s.escape_phase == ESC_DIGIT) begin
               has = 1'b1;
               ch  = cut_value(s);
            end
            pend = 1'b1;
         end
      end

      if (last_byte) begin
         s.value_phase  = 1'b0;
         s.escape_phase = ESC_NONE;
         s.pair_open    = 1'b0;
      end
   end

   assign state_nxt       = s;
   assign emit            = has || pend;
   assign result.has_char = has;
   assign result.out_byte = has ? ch : 8'd0;
   assign result.in_value = has ? state_cur.value_phase : 1'b0;
   assign result.pair_end = pend;

endmodule

[rtl/query_string_splitter_decoder.sv]
// Top level of the query string splitter and percent decoder: input beat
// register, parser state, result register. Depends on qssd_pkg, qssd_decode.
//
//   channel | direction | tdata          | tuser                       | tlast
//   req_    | in        | [7:0] byte     | -                           | last byte of string
//   rsp_    | out       | [7:0] out_byte | [0] has_char, [1] in_value  | pair end
//
// One byte per cycle sustained while rsp_tready stays high; a byte passes from req_
// to rsp_ through the input register, then is decoded into the result register.
// The parser state updates as a byte moves into the result register; a byte
// that yields nothing updates state and is dropped there.
// rsp_tready low holds the result; the input register still takes one beat.
// Synchronous active-high reset empties both registers and clears the state.
module query_string_splitter_decoder (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] data_byte
   input  logic       req_tlast,   // last_byte
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] out_byte
   output logic [1:0] rsp_tuser,   // [0] has_char, [1] in_value
   output logic       rsp_tlast    // pair_end
);
   import qssd_pkg::*;

   logic            in_valid_ff;
   logic            in_valid_in;
   logic [7:0]      in_byte_ff;
   logic            in_last_ff;
   logic            out_valid_ff;
   logic            out_valid_in;
   result_type      out_ff;
   parse_state_type state_ff;
   parse_state_type state_in;
   logic            emit;
   result_type      result;
   logic            advance;
   logic            req_fire;

   // Byte leaves the input register when the result register is free
   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign req_fire   = req_tvalid && req_tready;

   qssd_decode u_decode (
      .data_byte (in_byte_ff),
      .last_byte (in_last_ff),
      .state_cur (state_ff),
      .state_nxt (state_in),
      .emit      (emit),
      .result    (result)
   );

   assign in_valid_in  = req_fire || (in_valid_ff && !advance);
   assign out_valid_in = advance ? emit : (out_valid_ff && !rsp_tready);

   // Control and parser state
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff     <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (advance) begin
            state_ff <= state_in;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_byte_ff <= req_tdata;
         in_last_ff <= req_tlast;
      end
      if (advance) begin
         out_ff <= result;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_ff.out_byte;
   assign rsp_tuser  = {out_ff.in_value, out_ff.has_char};
   assign rsp_tlast  = out_ff.pair_end;

   // A closed pair leaves no value phase or escape behind
   a_closed_pair_clean: assert property (@(posedge clock) disable iff (reset)
      !state_ff.pair_open |-> (!state_ff.value_phase && state_ff.escape_phase == ESC_NONE))
      else $error("pair closed with parser state left over");

   // Escape progress never reaches the unused code
   a_escape_code: assert property (@(posedge clock) disable iff (reset)
      state_ff.escape_phase != 2'd3)
      else $error("escape phase out of range");

   // A result beat always carries a character or a pair end
   a_no_empty_beat: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> (out_ff.has_char || out_ff.pair_end))
      else $error("empty result beat");

   // Without a character the byte and the value flag are zero
   a_idle_fields: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !out_ff.has_char) |-> (out_ff.out_byte == 8'd0 && !out_ff.in_value))
      else $error("stray character fields");

endmodule

[bench/query_string_splitter_decoder_test.sv]
// Self-checking bench for query_string_splitter_decoder: directed byte table, then
// random query strings, with a bit-level decode predictor and random stalls on both sides.
// Depends on qssd_pkg (result_type, byte constants, escape codes) and the RTL top level.
`timescale 1ns / 100ps

module query_string_splitter_decoder_test;
   import qssd_pkg::*;

   localparam int RANDOM_BEATS = 1250;
   localparam int IDLE_PCT     = 37;
   localparam int HOLD_CYCLES  = 64;
   localparam int DRAIN_CYCLES = 20;
   localparam int REPORT_LIMIT = 10;

   // One input beat plus, for pinned table rows, the result typed in by hand
   typedef struct {
      logic [7:0] data;
      logic       last;
      bit         pinned;
      bit         yields;
      result_type want;
   } query_beat_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_tvalid = 1'b0;
   logic       req_tready;
   logic [7:0] req_tdata = 8'h00;
   logic       req_tlast = 1'b0;
   logic       rsp_tvalid;
   logic       rsp_tready = 1'b0;
   logic [7:0] rsp_tdata;
   logic [1:0] rsp_tuser;
   logic       rsp_tlast;

   query_beat_type query_beats[$];
   result_type     awaited_results[$];
   int             directed_count;
   int             fail_count = 0;
   int             result_count = 0;
   bit             calm = 1'b0;
   logic           squeeze = 1'b0;

   // Decoder state mirror
   logic       val_phase;
   logic [1:0] esc_step;
   logic [3:0] hi_nib;
   logic       hi_ok;
   logic       open_pair;

   query_string_splitter_decoder u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // {is_hex, digit value}; letters sit 9 above their low nibble
   function automatic logic [4:0] nibble_of(input logic [7:0] b);
      if (b inside {[8'h30:8'h39]}) begin
         return {1'b1, b[3:0]};
      end
      if (b inside {[8'h41:8'h46], [8'h61:8'h66]}) begin
         return {1'b1, b[3:0] + 4'd9};
      end
      return 5'b0_0000;
   endfunction

   // Advance the state mirror by one byte; yields is set when a beat comes out
   task automatic decode_byte(input logic [7:0] b, input logic l, output bit yields,
                              output result_type r);
      logic       phase_at_entry;
      logic [4:0] nib;
      logic       is_amp;
      logic       is_eq;
      phase_at_entry = val_phase;
      is_amp = (b == CH_AMP);
      is_eq  = (b == CH_EQ) && !val_phase;
      r = '0;
      if (is_amp || is_eq) begin
         // delimiter closes the piece; a half-read escape is flushed
         if (esc_step == ESC_DIGIT) begin
            r.has_char = 1'b1;
            r.out_byte = hi_ok ? {4'd0, hi_nib} : 8'd0;
         end
         esc_step = ESC_NONE;
         if (is_amp) begin
            r.pair_end = 1'b1;
            val_phase  = 1'b0;
            open_pair  = 1'b0;
         end else begin
            val_phase  = 1'b1;
            open_pair  = 1'b1;
            r.pair_end = l;
         end
      end else begin
         open_pair = 1'b1;
         case (esc_step)
            ESC_PCT: begin
               nib      = nibble_of(b);
               hi_ok    = nib[4];
               hi_nib   = nib[3:0];
               esc_step = ESC_DIGIT;
            end
            ESC_DIGIT: begin
               nib = nibble_of(b);
               r.has_char = 1'b1;
               if (!hi_ok) r.out_byte = 8'd0;
               else if (nib[4]) r.out_byte = {hi_nib, nib[3:0]};
               else r.out_byte = {4'd0, hi_nib};
               esc_step = ESC_NONE;
            end
            default: begin
               if (b == CH_PCT) begin
                  esc_step = ESC_PCT;
               end else begin
                  r.has_char = 1'b1;
                  r.out_byte = (b == CH_PLUS) ? CH_SPACE : b;
               end
            end
         endcase
         if (l) begin
            if (esc_step == ESC_DIGIT) begin
               r.has_char = 1'b1;
               r.out_byte = hi_ok ? {4'd0, hi_nib} : 8'd0;
            end
            r.pair_end = 1'b1;
         end
      end
      if (l) begin
         val_phase = 1'b0;
         esc_step  = ESC_NONE;
         open_pair = 1'b0;
      end
      r.in_value = r.has_char ? phase_at_entry : 1'b0;
      yields = r.has_char || r.pair_end;
   endtask

   task automatic add_free(input logic [7:0] d, input logic l);
      query_beat_type qb;
      qb.data = d;
      qb.last = l;
      qb.pinned = 1'b0;
      qb.yields = 1'b0;
      qb.want = '0;
      query_beats.push_back(qb);
   endtask

   task automatic add_pinned(input logic [7:0] d, input logic l, input bit some,
                             input logic has, input logic [7:0] ob, input logic inv,
                             input logic pend);
      query_beat_type qb;
      qb.data = d;
      qb.last = l;
      qb.pinned = 1'b1;
      qb.yields = some;
      qb.want.has_char = has;
      qb.want.out_byte = ob;
      qb.want.in_value = inv;
      qb.want.pair_end = pend;
      query_beats.push_back(qb);
   endtask

   function automatic logic [7:0] hex_char();
      int v;
      v = $urandom_range(0, 15);
      if (v < 10) return 8'h30 + 8'(v);
      return ($urandom_range(0, 1) ? 8'h41 : 8'h61) + 8'(v - 10);
   endfunction

   // One name or value: mostly plain text and good escapes, some broken ones
   task automatic build_piece(input int len);
      int pick;
      for (int k = 0; k < len; k++) begin
         pick = $urandom_range(0, 99);
         if (pick < 30) begin
            add_free(8'h61 + 8'($urandom_range(0, 25)), 1'b0);
         end else if (pick < 45) begin
            add_free(hex_char(), 1'b0);
         end else if (pick < 62) begin
            add_free(CH_PCT, 1'b0);
            add_free(hex_char(), 1'b0);
            add_free(hex_char(), 1'b0);
         end else if (pick < 68) begin
            add_free(CH_PCT, 1'b0);
            add_free($urandom_range(0, 3) == 0 ? hex_char() : 8'($urandom_range(0, 255)),
                     1'b0);
            add_free(8'($urandom_range(0, 255)), 1'b0);
         end else if (pick < 74) begin
            add_free(CH_PLUS, 1'b0);
         end else if (pick < 79) begin
            add_free(CH_EQ, 1'b0);
         end else if (pick < 84) begin
            add_free(CH_PCT, 1'b0);
         end else begin
            add_free(8'($urandom_range(0, 255)), $urandom_range(0, 19) == 0);
         end
      end
   endtask

   // One query string, last byte flagged
   task automatic build_query();
      int pairs;
      int start;
      start = query_beats.size();
      if ($urandom_range(0, 14) == 0) begin
         repeat ($urandom_range(1, 12)) add_free(8'($urandom_range(0, 255)), 1'b0);
      end else begin
         pairs = $urandom_range(1, 4);
         for (int p = 0; p < pairs; p++) begin
            build_piece($urandom_range(0, 6));
            if ($urandom_range(0, 9) < 8) begin
               add_free(CH_EQ, 1'b0);
               build_piece($urandom_range(0, 8));
            end
            if (p != pairs - 1 || $urandom_range(0, 9) == 0) add_free(CH_AMP, 1'b0);
         end
      end
      if (query_beats.size() == start) add_free(8'h61 + 8'($urandom_range(0, 25)), 1'b0);
      query_beats[query_beats.size() - 1].last = 1'b1;
   endtask

   // Result side: random stalls, one long hold while the sender keeps pushing
   initial begin : rsp_stall
      bit held;
      held = 1'b0;
      while (reset) @(posedge clock);
      forever begin
         @(posedge clock);
         if (squeeze && !held) begin
            held = 1'b1;
            rsp_tready <= 1'b0;
            for (int c = 0; c < HOLD_CYCLES; c++) @(posedge clock);
         end else begin
            rsp_tready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
         end
      end
   end

   // Compare each result beat with the oldest awaited one
   always @(posedge clock) begin : rsp_check
      result_type got;
      result_type exp;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = {rsp_tuser[0], rsp_tdata, rsp_tuser[1], rsp_tlast};
         if (awaited_results.size() == 0) begin
            fail_count++;
            if (fail_count <= REPORT_LIMIT)
               $display("unexpected beat: has_char %0b out_byte %02h in_value %0b pair_end %0b",
                        got.has_char, got.out_byte, got.in_value, got.pair_end);
         end else begin
            exp = awaited_results.pop_front();
            if (got.has_char !== exp.has_char || got.out_byte !== exp.out_byte ||
                got.in_value !== exp.in_value || got.pair_end !== exp.pair_end) begin
               fail_count++;
               if (fail_count <= REPORT_LIMIT) begin
                  $write("mismatch at beat %0d: has_char %0b/%0b out_byte %02h/%02h ",
                         result_count, exp.has_char, got.has_char, exp.out_byte,
                         got.out_byte);
                  $display("in_value %0b/%0b pair_end %0b/%0b (exp/got)",
                           exp.in_value, got.in_value, exp.pair_end, got.pair_end);
               end
            end
         end
         result_count++;
      end
   end

   initial begin : timeout
      #3_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

   // Stimulus, prediction on acceptance, drain and verdict
   initial begin : req_drive
      bit         yields;
      result_type res;
      val_phase = 1'b0;
      esc_step  = ESC_NONE;
      hi_nib    = 4'd0;
      hi_ok     = 1'b0;
      open_pair = 1'b0;

      // Directed table: typed results where they read straight off the rules
      add_pinned(8'h61, 1'b0, 1'b1, 1'b1, 8'h61, 1'b0, 1'b0);     // 'a' right after reset
      add_pinned(CH_PLUS, 1'b0, 1'b1, 1'b1, CH_SPACE, 1'b0, 1'b0);
      add_pinned(CH_PCT, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0);
      add_pinned(8'h34, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0);     // '4'
      add_pinned(8'h31, 1'b0, 1'b1, 1'b1, 8'h41, 1'b0, 1'b0);     // '1' -> 'A'
      add_pinned(CH_EQ, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0);     // name ends
      add_pinned(CH_EQ, 1'b0, 1'b1, 1'b1, CH_EQ, 1'b1, 1'b0);     // second '=' is data
      add_free(CH_PCT, 1'b0);
      add_free(8'h67, 1'b0);                                      // 'g': first digit not hex
      add_pinned(8'h46, 1'b0, 1'b1, 1'b1, 8'h00, 1'b1, 1'b0);     // gives zero
      add_free(CH_PCT, 1'b0);
      add_free(8'h66, 1'b0);                                      // 'f'
      add_pinned(8'h7A, 1'b0, 1'b1, 1'b1, 8'h0F, 1'b1, 1'b0);     // 'z': second not hex
      add_free(CH_PCT, 1'b0);
      add_free(8'h39, 1'b0);
      add_pinned(CH_AMP, 1'b0, 1'b1, 1'b1, 8'h09, 1'b1, 1'b1);    // escape cut by '&'
      add_pinned(CH_AMP, 1'b0, 1'b1, 1'b0, 8'h00, 1'b0, 1'b1);    // empty pair
      add_pinned(8'hFF, 1'b0, 1'b1, 1'b1, 8'hFF, 1'b0, 1'b0);
      add_pinned(8'h00, 1'b0, 1'b1, 1'b1, 8'h00, 1'b0, 1'b0);
      add_free(CH_PCT, 1'b0);
      add_pinned(8'h42, 1'b1, 1'b1, 1'b1, 8'h0B, 1'b0, 1'b1);     // escape cut by last byte
      add_free(8'h6B, 1'b0);
      add_pinned(CH_EQ, 1'b1, 1'b1, 1'b0, 8'h00, 1'b0, 1'b1);     // trailing "name="
      add_pinned(CH_PCT, 1'b1, 1'b1, 1'b0, 8'h00, 1'b0, 1'b1);    // bare '%' at the end
      add_pinned(CH_AMP, 1'b1, 1'b1, 1'b0, 8'h00, 1'b0, 1'b1);    // last byte '&'
      directed_count = query_beats.size();

      while (query_beats.size() < directed_count + RANDOM_BEATS) build_query();

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int i = 0; i < query_beats.size(); i++) begin
         calm = (i >= directed_count + 600) && (i < directed_count + 800);
         if (i == directed_count + 300) squeeze <= 1'b1;
         if (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
            req_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clock);
         end
         req_tvalid <= 1'b1;
         req_tdata  <= query_beats[i].data;
         req_tlast  <= query_beats[i].last;
         @(posedge clock);
         while (!req_tready) @(posedge clock);
         decode_byte(query_beats[i].data, query_beats[i].last, yields, res);
         if (query_beats[i].pinned) begin
            yields = query_beats[i].yields;
            res    = query_beats[i].want;
         end
         if (yields) awaited_results.push_back(res);
      end
      req_tvalid <= 1'b0;
      calm = 1'b0;

      while (awaited_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (fail_count == 0 && awaited_results.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
